// ===== sv/ahrs_qu_pkg.sv =====
// Types, constants and arithmetic helpers for the AHRS quaternion update pipeline.
// Holds the soft-float steps of the inverse square root. Depends on nothing.
package ahrs_qu_pkg;

  localparam int NS = 40;

  localparam logic [19:0] DT_RESET   = 20'd10486;
  localparam logic [19:0] GAIN_RESET = 20'd32768;
  localparam logic [31:0] MAGIC      = 32'h5F1F1412;
  localparam logic [23:0] DEG2HALFRAD = 24'd9370165;

  localparam logic REG_DT   = 1'b0;
  localparam logic REG_GAIN = 1'b1;

  typedef logic signed [11:0] exp_t;

  typedef struct packed {
    logic        neg;
    exp_t        e;
    logic [23:0] m;
  } sf_t;

  localparam exp_t KA_E = -12'sd23;
  localparam sf_t  KA   = '{neg: 1'b0, e: -12'sd23, m: 24'hD851FF};
  localparam sf_t  KB   = '{neg: 1'b0, e: -12'sd24, m: 24'hB6D312};

  typedef struct packed {
    sf_t         x;
    sf_t         y;
    sf_t         t;
    logic [47:0] p;
    exp_t        pe;
    logic        pz;
    logic        pneg;
    logic [63:0] sv;
    exp_t        se;
    logic        sneg;
  } isq_t;

  typedef struct packed {
    logic [3:0][17:0]  q;
    logic [2:0][25:0]  h;
    logic [2:0][19:0]  a;
    logic              anz;
    logic [2:0][39:0]  sq;
    logic [2:0][47:0]  gk;
    logic [2:0][21:0]  hg;
    logic [21:0]       magsq;
    isq_t              iq;
    logic [23:0]       inv;
    logic [2:0][43:0]  np;
    logic [2:0][25:0]  n;
    logic [5:0][51:0]  xp;
    logic [2:0][51:0]  dp;
    logic [2:0][25:0]  c;
    logic              dneg;
    logic [2:0][51:0]  csq;
    logic [2:0][49:0]  cp;
    logic [2:0][25:0]  fb;
    logic [2:0][46:0]  fg;
    logic [2:0][25:0]  adj;
    logic [11:0][43:0] qa;
    logic [3:0][26:0]  dq;
    logic [3:0][46:0]  dd;
    logic [3:0][47:0]  nq;
  } item_t;

  // round half up, then saturate to a signed w-bit range
  function automatic logic signed [63:0] rsat_s(input logic signed [63:0] v,
                                               input int unsigned k, input int unsigned w);
    logic signed [63:0] r, lo, hi;
    r  = (v + (64'sd1 <<< (k - 1))) >>> k;
    hi = (64'sd1 <<< (w - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (r < lo) r = lo;
    else if (r > hi) r = hi;
    return r;
  endfunction

  function automatic logic signed [63:0] rsat_u(input logic signed [63:0] v,
                                               input int unsigned k, input int unsigned w);
    logic signed [63:0] r, hi;
    r  = (v + (64'sd1 <<< (k - 1))) >>> k;
    hi = (64'sd1 <<< w) - 64'sd1;
    if (r < 64'sd0) r = 64'sd0;
    else if (r > hi) r = hi;
    return r;
  endfunction

  // round-to-nearest-even of a 24x24 mantissa product
  function automatic sf_t prod_pack(input exp_t e, input logic [47:0] p, input logic z);
    sf_t         r;
    logic [23:0] top;
    logic        rb, st, up;
    logic [24:0] mr;
    exp_t        eo;
    r = '0;
    if (p[47]) begin
      top = p[47:24]; rb = p[23]; st = |p[22:0]; eo = e + 12'sd24;
    end else begin
      top = p[46:23]; rb = p[22]; st = |p[21:0]; eo = e + 12'sd23;
    end
    up = rb & (st | top[0]);
    mr = {1'b0, top} + {24'd0, up};
    if (!z) begin
      if (mr[24]) begin
        r.m = 24'h800000; r.e = eo + 12'sd1;
      end else begin
        r.m = mr[23:0]; r.e = eo;
      end
    end
    return r;
  endfunction

  // normalize and round an arbitrary 64-bit magnitude to a 24-bit mantissa
  function automatic sf_t pack64(input logic neg, input exp_t base, input logic [63:0] v);
    sf_t         r;
    logic [5:0]  msb;
    logic [63:0] n;
    logic        up;
    logic [24:0] mr;
    exp_t        eo;
    r   = '0;
    msb = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) msb = 6'(i);
    end
    n  = v << (6'd63 - msb);
    eo = base + $signed({6'd0, msb}) - 12'sd23;
    up = n[39] & ((|n[38:0]) | n[40]);
    mr = {1'b0, n[63:40]} + {24'd0, up};
    if (v != 64'd0) begin
      r.neg = neg;
      if (mr[24]) begin
        r.m = 24'h800000; r.e = eo + 12'sd1;
      end else begin
        r.m = mr[23:0]; r.e = eo;
      end
    end
    return r;
  endfunction

  function automatic isq_t isq_k0(input logic [21:0] ms);
    isq_t        r;
    logic [31:0] bits, yi;
    exp_t        fe;
    r    = '0;
    r.x  = pack64(1'b0, -12'sd20, {42'd0, ms});
    fe   = r.x.e + 12'sd150;
    bits = (r.x.m != 24'd0) ? {1'b0, fe[7:0], r.x.m[22:0]} : 32'd0;
    yi   = MAGIC - {1'b0, bits[31:1]};
    r.y.neg = 1'b0;
    r.y.e   = $signed({4'd0, yi[30:23]}) - 12'sd150;
    r.y.m   = {1'b1, yi[22:0]};
    return r;
  endfunction

  function automatic isq_t isq_mul(input isq_t q, input sf_t a, input sf_t b);
    isq_t r;
    r      = q;
    r.p    = 48'(a.m * b.m);
    r.pe   = a.e + b.e;
    r.pz   = (a.m == 24'd0) || (b.m == 24'd0);
    r.pneg = a.neg ^ b.neg;
    return r;
  endfunction

  function automatic isq_t isq_pk(input isq_t q);
    isq_t r;
    r       = q;
    r.t     = prod_pack(q.pe, q.p, q.pz);
    r.t.neg = q.pz ? 1'b0 : q.pneg;
    return r;
  endfunction

  // Newton factor 1.69 - t with sticky alignment of the smaller operand
  function automatic isq_t isq_sub(input isq_t q);
    isq_t        r;
    logic        ka_big, aneg, bneg;
    logic [23:0] am, bm;
    exp_t        d, eb;
    logic [63:0] av, bf, bs;
    r      = q;
    ka_big = (KA_E >= q.t.e);
    if (ka_big) begin
      am = KA.m; bm = q.t.m; d = KA_E - q.t.e; aneg = 1'b0; bneg = 1'b1; eb = KA_E;
    end else begin
      am = q.t.m; bm = KA.m; d = q.t.e - KA_E; aneg = 1'b1; bneg = 1'b0; eb = q.t.e;
    end
    av = {8'd0, am, 32'd0};
    bf = {8'd0, bm, 32'd0};
    if (d >= 12'sd62) begin
      bs = 64'd1;
    end else begin
      bs = bf >> d[5:0];
      if ((bs << d[5:0]) != bf) bs[0] = 1'b1;
    end
    if (q.t.m == 24'd0) begin
      r.sv = {8'd0, KA.m, 32'd0}; r.se = KA_E - 12'sd32; r.sneg = 1'b0;
    end else if (av >= bs) begin
      r.sv = av - bs; r.se = eb - 12'sd32; r.sneg = aneg;
    end else begin
      r.sv = bs - av; r.se = eb - 12'sd32; r.sneg = bneg;
    end
    return r;
  endfunction

  function automatic isq_t isq_norm(input isq_t q);
    isq_t r;
    r   = q;
    r.t = pack64(q.sneg, q.se, q.sv);
    return r;
  endfunction

  // Q6.18 conversion with saturation
  function automatic logic [23:0] isq_out(input isq_t q);
    exp_t        s, k;
    logic [4:0]  kk;
    logic [25:0] tmp;
    logic [23:0] r;
    s   = q.t.e + 12'sd18;
    k   = -s;
    kk  = k[4:0];
    tmp = ({2'd0, q.t.m} + (26'd1 << (kk - 5'd1))) >> kk;
    if (q.t.m == 24'd0 || q.t.neg) r = 24'd0;
    else if (s > 12'sd0) r = 24'hFFFFFF;
    else if (s == 12'sd0) r = q.t.m;
    else if (k >= 12'sd26) r = 24'd0;
    else r = tmp[23:0];
    return r;
  endfunction

endpackage

// ===== sv/ahrs_qu_sample_if.sv =====
// Request channel carrying one IMU sample into the quaternion update block.
// Standalone; no package dependency.
interface ahrs_qu_sample_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] quat_w;
  logic signed [17:0] quat_x;
  logic signed [17:0] quat_y;
  logic signed [17:0] quat_z;
  logic signed [23:0] gyro_x;
  logic signed [23:0] gyro_y;
  logic signed [23:0] gyro_z;
  logic [59:0]        accel_xyz;
  logic signed [25:0] half_grav_x;
  logic signed [25:0] half_grav_y;
  logic signed [25:0] half_grav_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, gyro_x, gyro_y, gyro_z,
                  accel_xyz, half_grav_x, half_grav_y, half_grav_z, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, gyro_x, gyro_y, gyro_z,
                accel_xyz, half_grav_x, half_grav_y, half_grav_z, output ready);
endinterface

// ===== sv/ahrs_qu_result_if.sv =====
// Request channel carrying the updated, unnormalized quaternion out of the block.
// Standalone; no package dependency.
interface ahrs_qu_result_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] new_w;
  logic signed [47:0] new_x;
  logic signed [47:0] new_y;
  logic signed [47:0] new_z;

  modport source (output valid, new_w, new_x, new_y, new_z, input ready);
  modport sink (input valid, new_w, new_x, new_y, new_z, output ready);
endinterface

// ===== sv/ahrs_quaternion_update.sv =====
// AHRS quaternion update: 40-stage pipeline, APB config port, request channels.
// Depends on ahrs_qu_pkg, ahrs_qu_sample_if and ahrs_qu_result_if.
//
// Takes one sample per clock when the output is not stalled and returns its updated
// quaternion from the last stage; each stage holds at most one multiply or one
// wide add. The two accelerometer and cross-product normalizations each run a
// 12-stage soft-float inverse square root. Stages stall individually, so
// bubbles close up behind a waiting result. No clearing pass after reset.
module ahrs_quaternion_update import ahrs_qu_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  ahrs_qu_sample_if.sink     sample,
  ahrs_qu_result_if.source   result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [19:0]    delta_time;
  logic [19:0]    feedback_gain;
  logic [NS-1:0]  vld;
  logic [NS-1:0]  en;
  item_t          st  [NS];
  item_t          nxt [NS];

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delta_time    <= DT_RESET;
      feedback_gain <= GAIN_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_DT:   delta_time    <= pwdata[19:0];
        REG_GAIN: feedback_gain <= pwdata[19:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DT:   prdata = {12'd0, delta_time};
      REG_GAIN: prdata = {12'd0, feedback_gain};
    endcase
  end

  always_comb begin
    en[NS-1] = !vld[NS-1] || result.ready;
    for (int k = NS - 2; k >= 0; k--) en[k] = !vld[k] || en[k+1];
  end

  assign sample.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= sample.valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) st[k] <= nxt[k];
    end
  end

  always_comb begin
    logic signed [63:0] pq [12];
    logic signed [63:0] c2;
    int b;
    for (int k = 1; k < NS; k++) nxt[k] = st[k-1];

    // capture, squares, gyro scaling
    nxt[0]      = '0;
    nxt[0].q[0] = sample.quat_w;
    nxt[0].q[1] = sample.quat_x;
    nxt[0].q[2] = sample.quat_y;
    nxt[0].q[3] = sample.quat_z;
    nxt[0].h[0] = sample.half_grav_x;
    nxt[0].h[1] = sample.half_grav_y;
    nxt[0].h[2] = sample.half_grav_z;
    nxt[0].gk[0] = 48'($signed(sample.gyro_x) * $signed({1'b0, DEG2HALFRAD}));
    nxt[0].gk[1] = 48'($signed(sample.gyro_y) * $signed({1'b0, DEG2HALFRAD}));
    nxt[0].gk[2] = 48'($signed(sample.gyro_z) * $signed({1'b0, DEG2HALFRAD}));
    for (int i = 0; i < 3; i++) begin
      nxt[0].a[i]  = sample.accel_xyz[20*i +: 20];
      nxt[0].sq[i] = 40'($signed(sample.accel_xyz[20*i +: 20]) *
                         $signed(sample.accel_xyz[20*i +: 20]));
    end
    nxt[0].anz = |sample.accel_xyz;

    nxt[1].magsq = 22'(rsat_u(64'(st[0].sq[0]) + 64'(st[0].sq[1]) + 64'(st[0].sq[2]), 14, 22));
    for (int i = 0; i < 3; i++)
      nxt[1].hg[i] = 22'(rsat_s(64'($signed(st[0].gk[i])), 22, 22));

    // two inverse square roots, same step sequence
    for (int j = 0; j < 2; j++) begin
      b = (j == 0) ? 2 : 20;
      nxt[b].iq     = isq_k0(st[b-1].magsq);
      nxt[b+1].iq   = isq_mul(st[b].iq, KB, st[b].iq.x);
      nxt[b+2].iq   = isq_pk(st[b+1].iq);
      nxt[b+3].iq   = isq_mul(st[b+2].iq, st[b+2].iq.t, st[b+2].iq.y);
      nxt[b+4].iq   = isq_pk(st[b+3].iq);
      nxt[b+5].iq   = isq_mul(st[b+4].iq, st[b+4].iq.t, st[b+4].iq.y);
      nxt[b+6].iq   = isq_pk(st[b+5].iq);
      nxt[b+7].iq   = isq_sub(st[b+6].iq);
      nxt[b+8].iq   = isq_norm(st[b+7].iq);
      nxt[b+9].iq   = isq_mul(st[b+8].iq, st[b+8].iq.y, st[b+8].iq.t);
      nxt[b+10].iq  = isq_pk(st[b+9].iq);
      nxt[b+11].inv = isq_out(st[b+10].iq);
    end

    for (int i = 0; i < 3; i++) begin
      nxt[14].np[i] = 44'($signed(st[13].a[i]) * $signed({1'b0, st[13].inv}));
      nxt[15].n[i]  = 26'(rsat_s(64'($signed(st[14].np[i])), 11, 26));
      nxt[16].dp[i] = 52'($signed(st[15].n[i]) * $signed(st[15].h[i]));
    end
    nxt[16].xp[0] = 52'($signed(st[15].n[1]) * $signed(st[15].h[2]));
    nxt[16].xp[1] = 52'($signed(st[15].n[2]) * $signed(st[15].h[1]));
    nxt[16].xp[2] = 52'($signed(st[15].n[2]) * $signed(st[15].h[0]));
    nxt[16].xp[3] = 52'($signed(st[15].n[0]) * $signed(st[15].h[2]));
    nxt[16].xp[4] = 52'($signed(st[15].n[0]) * $signed(st[15].h[1]));
    nxt[16].xp[5] = 52'($signed(st[15].n[1]) * $signed(st[15].h[0]));

    for (int i = 0; i < 3; i++)
      nxt[17].c[i] = 26'(rsat_s(64'($signed(st[16].xp[2*i])) -
                                64'($signed(st[16].xp[2*i+1])), 24, 26));
    nxt[17].dneg = rsat_s(64'($signed(st[16].dp[0])) + 64'($signed(st[16].dp[1])) +
                          64'($signed(st[16].dp[2])), 23, 26) < 64'sd0;

    for (int i = 0; i < 3; i++)
      nxt[18].csq[i] = 52'($signed(st[17].c[i]) * $signed(st[17].c[i]));
    nxt[19].magsq = 22'(rsat_u(64'(st[18].csq[0]) + 64'(st[18].csq[1]) +
                               64'(st[18].csq[2]), 28, 22));

    for (int i = 0; i < 3; i++) begin
      nxt[32].cp[i] = 50'($signed(st[31].c[i]) * $signed({1'b0, st[31].inv}));
      c2 = rsat_s(64'($signed(st[32].cp[i])), 18, 26);
      nxt[33].fb[i] = !st[32].anz ? 26'd0 : (st[32].dneg ? 26'(c2) : st[32].c[i]);
      nxt[34].fg[i] = 47'($signed(st[33].fb[i]) * $signed({1'b0, feedback_gain}));
      nxt[35].adj[i] = 26'(rsat_s((64'($signed(st[34].hg[i])) <<< 20) +
                                  64'($signed(st[34].fg[i])), 19, 26));
    end

    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 3; j++)
        nxt[36].qa[i*3+j] = 44'($signed(st[35].q[i]) * $signed(st[35].adj[j]));
    end
    for (int i = 0; i < 12; i++) pq[i] = 64'($signed(st[36].qa[i]));
    nxt[37].dq[0] = 27'(rsat_s(-pq[3] - pq[7] - pq[11], 15, 27));
    nxt[37].dq[1] = 27'(rsat_s(pq[0] + pq[8] - pq[10], 15, 27));
    nxt[37].dq[2] = 27'(rsat_s(pq[1] - pq[5] + pq[9], 15, 27));
    nxt[37].dq[3] = 27'(rsat_s(pq[2] + pq[4] - pq[6], 15, 27));

    for (int i = 0; i < 4; i++) begin
      nxt[38].dd[i] = 47'($signed(st[37].dq[i]) * $signed({1'b0, delta_time}));
      nxt[39].nq[i] = 48'((64'($signed(st[38].q[i])) <<< 26) + 64'($signed(st[38].dd[i])));
    end
  end

  assign result.valid = vld[NS-1];
  assign result.new_w = st[NS-1].nq[0];
  assign result.new_x = st[NS-1].nq[1];
  assign result.new_y = st[NS-1].nq[2];
  assign result.new_z = st[NS-1].nq[3];

  a_accept: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> vld[0])
    else $error("accepted request did not enter the pipeline");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    vld[1] && !en[1] |=> vld[1] && $stable(st[1].magsq))
    else $error("stalled stage lost its contents");

  a_cfg_rst: assert property (@(posedge clk)
    $past(rst) |-> delta_time == DT_RESET && feedback_gain == GAIN_RESET)
    else $error("config registers not at reset values");

endmodule

// ===== test/ahrs_qu_tb_if.sv =====
`timescale 1ns / 100ps
// Testbench package with the register byte addresses used by the stimulus.
// Depends on nothing.
package ahrs_qu_tb_pkg;
  localparam logic [2:0] ADDR_DT   = 3'd0;
  localparam logic [2:0] ADDR_GAIN = 3'd4;
endpackage

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for ahrs_quaternion_update: random and directed IMU samples, and a bit-exact
// predictor of the fixed-point update. Uses ahrs_qu_pkg, ahrs_qu_tb_pkg, both interfaces.
module testbench;
  import ahrs_qu_pkg::*;
  import ahrs_qu_tb_pkg::*;

  typedef struct {
    logic signed [17:0] q [4];
    logic signed [23:0] g [3];
    logic [59:0]        acc;
    logic signed [25:0] h [3];
  } sample_t;

  typedef struct {
    logic [47:0] v [4];
  } quat_t;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  ahrs_qu_sample_if sample();
  ahrs_qu_result_if result();

  ahrs_quaternion_update uut (
    .clk(clk), .rst(rst), .sample(sample.sink), .result(result.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  quat_t  expected_quats[$];
  int     mismatches = 0;
  int     n_sent = 0, n_checked = 0;
  int     idle_pct = 23;
  int     hold_cycles = 0;
  logic [19:0] dt_reg, gain_reg;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("TEST FAILED");
    $finish;
  end

  // --- soft-float predictor of the inverse square root ---
  typedef struct { bit neg; int e; longint unsigned m; } flt_t;

  function automatic flt_t fpack(bit neg, int e, longint unsigned v);
    flt_t r;
    int len;
    longint unsigned t, rem, half;
    int s;
    r.neg = neg; r.e = 0; r.m = 0;
    if (v == 0) begin
      r.neg = 0;
      return r;
    end
    len = 0; t = v;
    while (t != 0) begin len++; t >>= 1; end
    if (len > 24) begin
      s = len - 24;
      rem = v & ((64'd1 << s) - 1);
      half = 64'd1 << (s - 1);
      v >>= s; e += s;
      if (rem > half || (rem == half && v[0])) v++;
      if (v == (64'd1 << 24)) begin v >>= 1; e++; end
    end else if (len < 24) begin
      s = 24 - len;
      v <<= s; e -= s;
    end
    r.e = e; r.m = v;
    return r;
  endfunction

  function automatic flt_t fmul(flt_t a, flt_t b);
    if (a.m == 0 || b.m == 0) return fpack(0, 0, 0);
    return fpack(a.neg != b.neg, a.e + b.e, a.m * b.m);
  endfunction

  function automatic flt_t fadd(flt_t a, flt_t b);
    flt_t t;
    longint unsigned av, bv, bs;
    int d;
    if (a.m == 0) return b;
    if (b.m == 0) return a;
    if (a.e < b.e) begin t = a; a = b; b = t; end
    d = a.e - b.e;
    av = a.m << 32; bv = b.m << 32;
    if (d >= 62) bs = 1;
    else begin
      bs = bv >> d;
      if ((bs << d) != bv) bs |= 1;
    end
    if (a.neg == b.neg) return fpack(a.neg, a.e - 32, av + bs);
    if (av >= bs) return fpack(a.neg, a.e - 32, av - bs);
    return fpack(b.neg, a.e - 32, bs - av);
  endfunction

  function automatic longint rsat(longint v, int k, longint lo, longint hi);
    if (k > 0) v = (v + (64'sd1 <<< (k - 1))) >>> k;
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint slo(int w);
    return -(64'sd1 <<< (w - 1));
  endfunction

  function automatic longint shi(int w);
    return (64'sd1 <<< (w - 1)) - 1;
  endfunction

  function automatic longint inverse_magnitude(longint magsq);
    flt_t x, y, ka, kb, t, r;
    bit [31:0] bits, yi;
    int s;
    x = fpack(0, -20, magsq);
    bits = 0;
    if (x.m != 0) bits = {1'b0, 8'(x.e + 150), x.m[22:0]};
    yi = MAGIC - (bits >> 1);
    y.neg = 0; y.e = int'(yi[30:23]) - 150; y.m = {40'd0, 1'b1, yi[22:0]};
    ka.neg = 0; ka.e = -23; ka.m = 64'hD851FF;
    kb.neg = 0; kb.e = -24; kb.m = 64'hB6D312;
    t = fmul(fmul(fmul(kb, x), y), y);
    t.neg = !t.neg;
    r = fmul(y, fadd(ka, t));
    if (r.m == 0 || r.neg) return 0;
    s = r.e + 18;
    if (s >= 0) begin
      if (s > 6) return 64'hFFFFFF;
      return rsat(longint'(r.m << s), 0, 0, 64'hFFFFFF);
    end
    if (-s > 40) return 0;
    return rsat(longint'(r.m), -s, 0, 64'hFFFFFF);
  endfunction

  function automatic quat_t quaternion_step(sample_t s);
    quat_t  o;
    longint q[4], g[3], a[3], h[3], fb[3], adj[3], dq[4], n[3], c[3];
    longint inv, dot, hg, v;
    for (int i = 0; i < 4; i++) q[i] = s.q[i];
    for (int i = 0; i < 3; i++) begin
      g[i] = s.g[i];
      a[i] = longint'($signed(s.acc[20*i +: 20]));
      h[i] = s.h[i];
      fb[i] = 0;
    end
    if (a[0] != 0 || a[1] != 0 || a[2] != 0) begin
      inv = inverse_magnitude(rsat(a[0]*a[0] + a[1]*a[1] + a[2]*a[2], 14, 0, 64'h3FFFFF));
      for (int i = 0; i < 3; i++) n[i] = rsat(a[i] * inv, 11, slo(26), shi(26));
      c[0] = rsat(n[1]*h[2] - n[2]*h[1], 24, slo(26), shi(26));
      c[1] = rsat(n[2]*h[0] - n[0]*h[2], 24, slo(26), shi(26));
      c[2] = rsat(n[0]*h[1] - n[1]*h[0], 24, slo(26), shi(26));
      dot = rsat(n[0]*h[0] + n[1]*h[1] + n[2]*h[2], 23, slo(26), shi(26));
      if (dot < 0) begin
        inv = inverse_magnitude(rsat(c[0]*c[0] + c[1]*c[1] + c[2]*c[2], 28, 0, 64'h3FFFFF));
        for (int i = 0; i < 3; i++) c[i] = rsat(c[i] * inv, 18, slo(26), shi(26));
      end
      for (int i = 0; i < 3; i++) fb[i] = c[i];
    end
    for (int i = 0; i < 3; i++) begin
      hg = rsat(g[i] * 9370165, 22, slo(22), shi(22));
      adj[i] = rsat(hg * (64'sd1 <<< 20) + fb[i] * longint'(gain_reg), 19, slo(26), shi(26));
    end
    dq[0] = rsat(-q[1]*adj[0] - q[2]*adj[1] - q[3]*adj[2], 15, slo(27), shi(27));
    dq[1] = rsat(q[0]*adj[0] + q[2]*adj[2] - q[3]*adj[1], 15, slo(27), shi(27));
    dq[2] = rsat(q[0]*adj[1] - q[1]*adj[2] + q[3]*adj[0], 15, slo(27), shi(27));
    dq[3] = rsat(q[0]*adj[2] + q[1]*adj[1] - q[2]*adj[0], 15, slo(27), shi(27));
    for (int i = 0; i < 4; i++) begin
      v = q[i] * (64'sd1 <<< 26) + dq[i] * longint'(dt_reg);
      o.v[i] = v[47:0];
    end
    return o;
  endfunction

  // --- stimulus ---
  task automatic send_sample(sample_t s);
    sample.valid       <= 1'b1;
    sample.quat_w      <= s.q[0];
    sample.quat_x      <= s.q[1];
    sample.quat_y      <= s.q[2];
    sample.quat_z      <= s.q[3];
    sample.gyro_x      <= s.g[0];
    sample.gyro_y      <= s.g[1];
    sample.gyro_z      <= s.g[2];
    sample.accel_xyz   <= s.acc;
    sample.half_grav_x <= s.h[0];
    sample.half_grav_y <= s.h[1];
    sample.half_grav_z <= s.h[2];
    do @(posedge clk); while (!sample.ready);
    expected_quats.push_back(quaternion_step(s));
    n_sent++;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      sample.valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [2:0] addr, logic [19:0] value);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= {12'd0, value};
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == ADDR_DT) dt_reg = value;
    else if (addr == ADDR_GAIN) gain_reg = value;
  endtask

  task automatic drain();
    sample.valid <= 1'b0;
    while (expected_quats.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  function automatic logic [59:0] pack_accel(int ax, int ay, int az);
    return {20'(az), 20'(ay), 20'(ax)};
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int unit;
    unit = $urandom_range(3);
    for (int i = 0; i < 4; i++) begin
      if (unit != 0) s.q[i] = 18'($signed($urandom_range(0, 131072)) - 65536);
      else s.q[i] = 18'($urandom);
    end
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(3))
        0: s.g[i] = 24'($urandom);
        default: s.g[i] = 24'($signed($urandom_range(0, 2000000)) - 1000000);
      endcase
      if (unit != 0) s.h[i] = 26'($signed($urandom_range(0, 16777216)) - 8388608);
      else s.h[i] = 26'($urandom);
    end
    case ($urandom_range(9))
      0: s.acc = '0;
      1: s.acc = 60'({$urandom, $urandom});
      2: s.acc = pack_accel($urandom_range(0, 3) - 1, $urandom_range(0, 3) - 1,
                            $urandom_range(0, 3) - 1);
      default: s.acc = pack_accel($urandom_range(0, 262144) - 131072,
                                  $urandom_range(0, 262144) - 131072,
                                  $urandom_range(0, 262144) - 131072);
    endcase
    return s;
  endfunction

  function automatic sample_t make_sample(logic signed [17:0] qv, logic signed [23:0] gv,
                                          logic [59:0] acc, logic signed [25:0] hv);
    sample_t s;
    for (int i = 0; i < 4; i++) s.q[i] = qv;
    for (int i = 0; i < 3; i++) begin s.g[i] = gv; s.h[i] = hv; end
    s.acc = acc;
    return s;
  endfunction

  task automatic test_directed();
    sample_t s;
    send_sample(make_sample(18'sd65536, 24'sd0, '0, 26'sd0));
    send_sample(make_sample(18'sd65536, 24'sd409600, '0, 26'sd0));
    send_sample(make_sample(18'sh20000, 24'sh800000, '1, 26'sh2000000));
    send_sample(make_sample(18'sd131071, 24'sd8388607, {3{20'h7FFFF}}, 26'sd33554431));
    send_sample(make_sample(18'sd131071, 24'sd8388607, {3{20'h80000}}, 26'sh2000000));
    send_sample(make_sample(18'sd32768, 24'sd1000, pack_accel(0, 0, 131072), 26'sd8388608));
    send_sample(make_sample(18'sd32768, 24'sd1000, pack_accel(0, 0, -131072), 26'sd8388608));
    send_sample(make_sample(18'sd32768, -24'sd1000, pack_accel(1, 0, 0), 26'sd8388608));
    send_sample(make_sample(18'sd32768, -24'sd1000, pack_accel(1, 1, 1), -26'sd8388608));
    s = make_sample(18'sd65536, 24'sd0, pack_accel(131072, 0, 0), 26'sd0);
    s.h[0] = -26'sd8388608;
    send_sample(s);
    s.h[0] = 26'sd8388608; s.acc = pack_accel(-131072, 0, 0);
    send_sample(s);
    s = make_sample(18'sd0, 24'sd0, pack_accel(100000, -100000, 50000), 26'sd0);
    s.h[2] = 26'sd8388608;
    send_sample(s);
    drain();
  endtask

  task automatic test_random(int count, int pct);
    idle_pct = pct;
    repeat (count) send_sample(random_sample());
    drain();
  endtask

  task automatic test_output_backpressure();
    hold_cycles = 200;
    repeat (80) send_sample(random_sample());
    drain();
  endtask

  task automatic test_config_sweep();
    logic [19:0] dts[4], gains[4];
    dts = '{20'd0, 20'hFFFFF, 20'd10486, 20'd1};
    gains = '{20'hFFFFF, 20'd0, 20'd65536, 20'd32768};
    for (int i = 0; i < 4; i++) begin
      write_reg(ADDR_DT, dts[i]);
      write_reg(ADDR_GAIN, gains[i]);
      test_random(100, 23);
    end
  endtask

  // --- result checker and receiver stalls ---
  task automatic report_mismatch(string field, logic [47:0] got, logic [47:0] want);
    mismatches++;
    $display("mismatch at result %0d: %s got %h expected %h", n_checked, field, got, want);
  endtask

  initial begin
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        result.ready <= 1'b0;
        hold_cycles--;
      end else begin
        result.ready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    quat_t e;
    if (!rst && result.valid && result.ready) begin
      if (expected_quats.size() == 0) begin
        report_mismatch("unexpected result new_w", result.new_w, 48'bx);
      end else begin
        e = expected_quats.pop_front();
        if (result.new_w !== e.v[0]) report_mismatch("new_w", result.new_w, e.v[0]);
        if (result.new_x !== e.v[1]) report_mismatch("new_x", result.new_x, e.v[1]);
        if (result.new_y !== e.v[2]) report_mismatch("new_y", result.new_y, e.v[2]);
        if (result.new_z !== e.v[3]) report_mismatch("new_z", result.new_z, e.v[3]);
      end
      n_checked++;
    end
  end

  initial begin
    sample.valid = 0;
    sample.quat_w = 0; sample.quat_x = 0; sample.quat_y = 0; sample.quat_z = 0;
    sample.gyro_x = 0; sample.gyro_y = 0; sample.gyro_z = 0;
    sample.accel_xyz = 0;
    sample.half_grav_x = 0; sample.half_grav_y = 0; sample.half_grav_z = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    dt_reg = DT_RESET; gain_reg = GAIN_RESET;
    rst = 1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_directed();
    test_random(200, 0);
    test_output_backpressure();
    test_config_sweep();
    write_reg(ADDR_DT, DT_RESET);
    write_reg(ADDR_GAIN, GAIN_RESET);
    test_random(320, 23);
    $display("covered %0d samples, %0d results, 4 register settings plus reset values",
             n_sent, n_checked);
    if (mismatches == 0 && expected_quats.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== ahrs_quaternion_update.f =====
sv/ahrs_qu_pkg.sv
sv/ahrs_qu_sample_if.sv
sv/ahrs_qu_result_if.sv
sv/ahrs_quaternion_update.sv
test/ahrs_qu_tb_if.sv
test/testbench.sv
